// File: hw/rtl/lazy_prim_spanning_tree_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the lazy Prim spanning tree block
// Wrap concurrent checks so that synthesis sees nothing.
// ---------------------------------------------------------------------------
`ifndef LAZY_PRIM_SPANNING_TREE_MACROS_SVH
`define LAZY_PRIM_SPANNING_TREE_MACROS_SVH
`ifndef SYNTHESIS
// condition implies property in the same cycle
`define LPST_ASSERT_IMP(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("lpst assertion failed");
// condition implies property in the next cycle
`define LPST_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("lpst assertion failed");
`else
`define LPST_ASSERT_IMP(lbl, clk, rst, cond, prop)
`define LPST_ASSERT_NEXT(lbl, clk, rst, cond, prop)
`endif
`endif

// File: hw/rtl/lpst_pkg.sv
// ---------------------------------------------------------------------------
// lpst_pkg
// Field widths and operation codes shared by the spanning tree block.
// ---------------------------------------------------------------------------
package lpst_pkg;
  localparam int OP_W  = 2;
  localparam int VTX_W = 6;
  localparam int WGT_W = 16;
  localparam int CNT_W = 7;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CNT_W-1:0] VCOUNT_RESET = 7'd64;
endpackage

// File: hw/rtl/lpst_if.sv
// ---------------------------------------------------------------------------
// lpst channel interfaces
// Valid/ready channels for command items and tree results.
// ---------------------------------------------------------------------------
interface lpst_item_if import lpst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [VTX_W-1:0] first_vertex;
  logic [VTX_W-1:0] second_vertex;
  logic signed [WGT_W-1:0] edge_weight;

  modport source(output valid, operation, first_vertex, second_vertex, edge_weight,
                 input ready);
  modport sink(input valid, operation, first_vertex, second_vertex, edge_weight,
               output ready);
endinterface

interface lpst_result_if import lpst_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VTX_W-1:0] tree_vertex;
  logic [VTX_W-1:0] new_vertex;
  logic signed [WGT_W-1:0] tree_edge_weight;
  logic             edge_valid;
  logic             last_result;
  logic             load_dropped;

  modport source(output valid, tree_vertex, new_vertex, tree_edge_weight, edge_valid,
                 last_result, load_dropped, input ready);
  modport sink(input valid, tree_vertex, new_vertex, tree_edge_weight, edge_valid,
               last_result, load_dropped, output ready);
endinterface

// File: hw/rtl/lazy_prim_spanning_tree.sv
// Throughput: one command at a time; the edge store and queue RAMs each serve one
//   read and one write per cycle, and each queue scan/shift walks the RAM once.
// Reset: synchronous, active high; counts, marks, drop flag and handshakes clear,
//   vertex_count returns to 64. RAM contents are not cleared.
// ---------------------------------------------------------------------------
// lazy_prim_spanning_tree
// Stores weighted edges and emits the minimum spanning tree from vertex 0
// with lazy Prim over a RAM-resident edge queue.
// ---------------------------------------------------------------------------
`include "lazy_prim_spanning_tree_macros.svh"

module lazy_prim_spanning_tree import lpst_pkg::*; #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [CNT_W-1:0] wr_data,
  lpst_item_if.sink        items,
  lpst_result_if.source    results
);
  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int SAW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int QD   = 2 * MAX_EDGES;
  localparam int QAW  = $clog2(QD);
  localparam int SCW  = $clog2(MAX_EDGES + 1);
  localparam int QCW  = $clog2(QD + 1);
  localparam int SDW  = 2 * VW + WEIGHT_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_VISIT  = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  // Architectural state
  logic [CNT_W-1:0]        vertex_count;
  logic [SCW-1:0]          stored;
  logic                    drop_flag;
  logic [MAX_VERTICES-1:0] marks;
  logic [QCW-1:0]          qfill;
  logic [2:0]              state;

  // Sequencer registers
  logic [VW-1:0]  cur_vtx;
  logic [QCW-1:0] cnt;
  logic           p1_valid;
  logic [QCW-1:0] p1_idx;
  logic           p2_valid;
  logic [QAW-1:0] p2_idx;
  logic [QAW-1:0] p2_h;

  // Lightest half found by the current scan
  logic                          best_any;
  logic [QAW-1:0]                best_idx;
  logic [QAW-1:0]                best_h;
  logic [VW-1:0]                 best_a;
  logic [VW-1:0]                 best_b;
  logic signed [WEIGHT_BITS-1:0] best_w;

  // One result held back until the next one shows whether it is the last
  logic             pend_valid;
  logic [VW-1:0]    pend_t;
  logic [VW-1:0]    pend_n;
  logic [WGT_W-1:0] pend_w;

  // Output register
  logic             out_valid;
  logic [VTX_W-1:0] out_tv;
  logic [VTX_W-1:0] out_nv;
  logic [WGT_W-1:0] out_w;
  logic             out_ev;
  logic             out_last;
  logic             out_drop;

  logic [CNT_W-1:0] n_eff;
  always_comb begin
    if (vertex_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (vertex_count > CNT_W'(MAX_VERTICES)) begin
      n_eff = CNT_W'(MAX_VERTICES);
    end else begin
      n_eff = vertex_count;
    end
  end

  // Memories
  logic           s_we;
  logic [SAW-1:0] s_waddr;
  logic [SDW-1:0] s_wdata;
  logic [SAW-1:0] s_raddr;
  logic [SDW-1:0] s_rdata;
  logic           q_we;
  logic [QAW-1:0] q_waddr;
  logic [QAW-1:0] q_wdata;
  logic [QAW-1:0] q_raddr;
  logic [QAW-1:0] q_rdata;

  lpst_ram #(.WIDTH(SDW), .DEPTH(MAX_EDGES)) u_store (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  lpst_ram #(.WIDTH(QAW), .DEPTH(QD)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  logic [VW-1:0]                 sa;
  logic [VW-1:0]                 sb;
  logic signed [WEIGHT_BITS-1:0] sw;
  assign sa = s_rdata[SDW-1 -: VW];
  assign sb = s_rdata[WEIGHT_BITS +: VW];
  assign sw = s_rdata[WEIGHT_BITS-1:0];

  // Load path: low WEIGHT_BITS of the weight, zero-filled above 16 bits
  logic [31:0]                   w_wide;
  logic signed [WEIGHT_BITS-1:0] w_in;
  logic                          in_xfer;
  logic                          add_ok;
  assign w_wide  = {16'b0, items.edge_weight};
  assign w_in    = w_wide[WEIGHT_BITS-1:0];
  assign in_xfer = items.valid && items.ready;
  assign add_ok  = (stored < SCW'(MAX_EDGES))
                && ({1'b0, items.first_vertex} < n_eff)
                && ({1'b0, items.second_vertex} < n_eff);

  // Visit stage: push the half leaving the visited vertex
  logic           v_edge_ok;
  logic           push0;
  logic           push1;
  logic           push;
  logic [QAW-1:0] push_h;
  assign v_edge_ok = (CNT_W'(sa) < n_eff) && (CNT_W'(sb) < n_eff);
  assign push0 = v_edge_ok && (sa == cur_vtx) && !marks[sb];
  assign push1 = v_edge_ok && (sb == cur_vtx) && !marks[sa];
  assign push  = (state == S_VISIT) && p1_valid && (push0 || push1)
              && (qfill < QCW'(QD));
  assign push_h = QAW'({p1_idx, !push0});

  logic visit_issue;
  logic queue_issue;
  assign visit_issue = (cnt < QCW'(stored));
  assign queue_issue = (cnt < qfill);

  // Decide stage
  logic [VW-1:0] d_from;
  logic [VW-1:0] d_to;
  logic          m_from;
  logic          m_to;
  logic [VW-1:0] d_tv;
  logic [VW-1:0] d_nv;
  logic          out_free;
  logic          out_load;
  logic [31:0]   best_w32;
  assign d_from   = best_h[0] ? best_b : best_a;
  assign d_to     = best_h[0] ? best_a : best_b;
  assign m_from   = marks[d_from];
  assign m_to     = marks[d_to];
  assign d_tv     = m_from ? d_from : d_to;
  assign d_nv     = m_from ? d_to : d_from;
  assign out_free = !out_valid || results.ready;
  assign best_w32 = 32'(best_w);
  // the output register takes a new result: a held edge or the closing one
  assign out_load = out_free
                 && (((state == S_DECIDE) && !(m_from && m_to) && pend_valid)
                  || (state == S_FINISH));

  // Memory port steering
  always_comb begin
    s_we    = in_xfer && (items.operation == OP_ADD) && add_ok;
    s_waddr = SAW'(stored);
    s_wdata = {VW'(items.first_vertex), VW'(items.second_vertex), w_in};
    s_raddr = (state == S_SCAN) ? SAW'(q_rdata >> 1) : SAW'(cnt);
    q_we    = push || ((state == S_SHIFT) && p1_valid);
    q_waddr = push ? QAW'(qfill) : QAW'(p1_idx - 1'b1);
    q_wdata = push ? push_h : q_rdata;
    q_raddr = QAW'(cnt);
  end

  assign items.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
      stored       <= '0;
      drop_flag    <= 1'b0;
      marks        <= '0;
      qfill        <= '0;
      state        <= S_IDLE;
      p1_valid     <= 1'b0;
      p2_valid     <= 1'b0;
      pend_valid   <= 1'b0;
      out_valid    <= 1'b0;
      best_any     <= 1'b0;
    end else begin
      if (wr_en) begin
        vertex_count <= wr_data;
      end
      // load a new result, else drop the output once it transfers
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            case (items.operation)
              OP_ADD: begin
                if (add_ok) begin
                  stored <= stored + 1'b1;
                end else begin
                  drop_flag <= 1'b1;
                end
              end
              OP_RUN: begin
                marks    <= MAX_VERTICES'(1);
                cur_vtx  <= '0;
                qfill    <= '0;
                cnt      <= '0;
                p1_valid <= 1'b0;
                state    <= S_VISIT;
              end
              OP_CLEAR: begin
                stored    <= '0;
                qfill     <= '0;
                drop_flag <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_VISIT: begin
          p1_valid <= visit_issue;
          p1_idx   <= cnt;
          if (visit_issue) begin
            cnt <= cnt + 1'b1;
          end
          if (push) begin
            qfill <= qfill + 1'b1;
          end
          if (!visit_issue && !p1_valid) begin
            cnt      <= '0;
            best_any <= 1'b0;
            p2_valid <= 1'b0;
            // an edge pushed in this cycle cannot happen here: pipeline is empty
            state    <= (qfill == '0) ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          p1_valid <= queue_issue;
          p1_idx   <= cnt;
          if (queue_issue) begin
            cnt <= cnt + 1'b1;
          end
          p2_valid <= p1_valid;
          p2_idx   <= QAW'(p1_idx);
          p2_h     <= q_rdata;
          if (p2_valid && (!best_any || (sw < best_w))) begin
            best_any <= 1'b1;
            best_idx <= p2_idx;
            best_h   <= p2_h;
            best_a   <= sa;
            best_b   <= sb;
            best_w   <= sw;
          end
          if (!queue_issue && !p1_valid && !p2_valid) begin
            cnt   <= QCW'(best_idx) + 1'b1;
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          p1_valid <= queue_issue;
          p1_idx   <= cnt;
          if (queue_issue) begin
            cnt <= cnt + 1'b1;
          end
          if (!queue_issue && !p1_valid) begin
            qfill <= qfill - 1'b1;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (m_from && m_to) begin
            cnt      <= '0;
            best_any <= 1'b0;
            p1_valid <= 1'b0;
            p2_valid <= 1'b0;
            state    <= (qfill == '0) ? S_FINISH : S_SCAN;
          end else if (!pend_valid || out_free) begin
            if (pend_valid) begin
              out_tv    <= VTX_W'(pend_t);
              out_nv    <= VTX_W'(pend_n);
              out_w     <= pend_w;
              out_ev    <= 1'b1;
              out_last  <= 1'b0;
              out_drop  <= drop_flag;
            end
            pend_valid   <= 1'b1;
            pend_t       <= d_tv;
            pend_n       <= d_nv;
            pend_w       <= best_w32[WGT_W-1:0];
            marks[d_nv]  <= 1'b1;
            cur_vtx      <= d_nv;
            cnt          <= '0;
            p1_valid     <= 1'b0;
            state        <= S_VISIT;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_tv     <= pend_valid ? VTX_W'(pend_t) : '0;
            out_nv     <= pend_valid ? VTX_W'(pend_n) : '0;
            out_w      <= pend_valid ? pend_w : '0;
            out_ev     <= pend_valid;
            out_last   <= 1'b1;
            out_drop   <= drop_flag;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid            = out_valid;
  assign results.tree_vertex      = out_tv;
  assign results.new_vertex       = out_nv;
  assign results.tree_edge_weight = out_w;
  assign results.edge_valid       = out_ev;
  assign results.last_result      = out_last;
  assign results.load_dropped     = out_drop;

  // Checks
  `LPST_ASSERT_IMP(a_queue_bound, clk, rst, 1'b1, qfill <= QCW'(QD))
  `LPST_ASSERT_IMP(a_store_bound, clk, rst, 1'b1, stored <= SCW'(MAX_EDGES))
  `LPST_ASSERT_IMP(a_idle_no_pend, clk, rst, state == S_IDLE, !pend_valid)
  `LPST_ASSERT_NEXT(a_run_marks_root, clk, rst, in_xfer && items.operation == OP_RUN,
                    marks[0] && state == S_VISIT)
endmodule

// File: hw/rtl/lpst_ram.sv
// ---------------------------------------------------------------------------
// lpst_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lpst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
